// File: rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

  localparam int unsigned MaxRawBytesDef = 256;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueueAw        = $clog2(QueueDepth);
  localparam int unsigned DepthW         = 9;
  localparam logic [DepthW-1:0] DepthMax = '1;

  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0c;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLess      = 8'h3c;
  localparam logic [7:0] ChGreater   = 8'h3e;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;
  localparam logic [7:0] ChLowN      = 8'h6e;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowB      = 8'h62;

  typedef enum logic [1:0] {
    StComplete    = 2'd0,
    StNoString    = 2'd1,
    StEndOfInput  = 2'd2,
    StLengthLimit = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EscByte,
    EscCr,
    EscLf,
    EscOct
  } esc_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] end_status;
  } out_t;

  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
    logic       is_space;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] hex_val;
    esc_e       esc_kind;
    logic [7:0] esc_byte;
  } tok_t;

endpackage
`default_nettype wire

// File: rtl/pdf_string_token_decoder.sv
`default_nettype none
// PDF string token decoder. Takes one raw byte per request and sustains one
// request per cycle while the queue is not full; a byte that yields two
// decoded results holds the second in a spill register behind the result
// register, and that register sets the rate. A request passes a classifier
// into a four-entry queue, and the decoder behind it pulls one entry a cycle,
// unless the output stalls or a spill is pending, into its state and result
// register. Literal strings close on the matching parenthesis, hex strings on
// '>', and any string closes after MaxRawBytes raw bytes; the last result of
// each string has string_done set and carries end_status.
module pdf_string_token_decoder #(
  parameter int unsigned MaxRawBytes = psd_pkg::MaxRawBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire psd_pkg::in_t  in_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output psd_pkg::out_t      out_o,
  input  wire logic          out_stall_i
);
  import psd_pkg::*;

  logic push;
  logic full;
  tok_t push_tok;
  logic q_valid;
  tok_t q_tok;
  logic pop;

  psd_front u_front (
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  psd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (full),
    .valid_o (q_valid),
    .tok_o   (q_tok),
    .pop_i   (pop)
  );

  psd_back #(
    .MaxRawBytes (MaxRawBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .tok_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

// File: rtl/psd_front.sv
`default_nettype none
module psd_front (
  input  wire logic          in_valid_i,
  input  wire psd_pkg::in_t  in_i,
  output logic               in_stall_o,
  input  wire logic          full_i,
  output logic               push_o,
  output psd_pkg::tok_t      tok_o
);
  import psd_pkg::*;

  logic [7:0] ch;

  assign ch         = in_i.data_byte;
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    tok_o          = '0;
    tok_o.eoi      = in_i.end_of_input;
    tok_o.ch       = ch;
    tok_o.is_space = (ch == ChSpace) || (ch == ChNul) || ((ch >= ChTab) && (ch <= ChCr));
    tok_o.is_oct   = (ch >= ChZero) && (ch <= ChSeven);
    tok_o.is_hex   = 1'b1;
    if ((ch >= ChZero) && (ch <= ChNine)) begin
      tok_o.hex_val = 4'(ch - ChZero);
    end else if ((ch >= ChLowA) && (ch <= ChLowF)) begin
      tok_o.hex_val = 4'(ch - ChLowA + 8'd10);
    end else if ((ch >= ChUpA) && (ch <= ChUpF)) begin
      tok_o.hex_val = 4'(ch - ChUpA + 8'd10);
    end else begin
      tok_o.is_hex  = 1'b0;
    end
    tok_o.esc_kind = EscByte;
    tok_o.esc_byte = ch;
    priority if (ch == ChLowN) begin
      tok_o.esc_byte = ChLf;
    end else if (ch == ChLowR) begin
      tok_o.esc_byte = ChCr;
    end else if (ch == ChLowT) begin
      tok_o.esc_byte = ChTab;
    end else if (ch == ChLowB) begin
      tok_o.esc_byte = ChBs;
    end else if (ch == ChLowF) begin
      tok_o.esc_byte = ChFf;
    end else if (ch == ChCr) begin
      tok_o.esc_kind = EscCr;
    end else if (ch == ChLf) begin
      tok_o.esc_kind = EscLf;
    end else if (tok_o.is_oct) begin
      tok_o.esc_kind = EscOct;
    end else begin
      tok_o.esc_kind = EscByte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/psd_queue.sv
`default_nettype none
module psd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire psd_pkg::tok_t  tok_i,
  output logic                full_o,
  output logic                valid_o,
  output psd_pkg::tok_t       tok_o,
  input  wire logic           pop_i
);
  import psd_pkg::*;

  tok_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]     count_q, count_d;
  logic                 do_pop;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    unique case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/psd_back.sv
`default_nettype none
module psd_back #(
  parameter int unsigned MaxRawBytes = psd_pkg::MaxRawBytesDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           tok_valid_i,
  input  wire psd_pkg::tok_t  tok_i,
  output logic                tok_pop_o,
  output logic                out_valid_o,
  output psd_pkg::out_t       out_o,
  input  wire logic           out_stall_i
);
  import psd_pkg::*;

  localparam int unsigned RawW = $clog2(MaxRawBytes);

  typedef enum logic [1:0] {
    ModeIdle,
    ModeLit,
    ModeHex
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              esc_q, esc_d;
  logic              nlskip_q, nlskip_d;
  logic              oct_act_q, oct_act_d;
  logic [7:0]        oct_val_q, oct_val_d;
  logic [1:0]        oct_dig_q, oct_dig_d;
  logic              nib_q, nib_d;
  logic [3:0]        hi_q, hi_d;
  logic [RawW-1:0]   raw_q, raw_d;

  logic              out_valid_q;
  out_t              out_q;
  logic              spill_valid_q;
  out_t              spill_q;

  logic [1:0]        nb;
  logic [7:0]        b0, b1;
  logic              done, closed, plain, limit;
  status_e           status;
  logic [1:0]        n_res;
  out_t              r0, r1;
  logic              out_free;

  assign limit = (raw_q == RawW'(MaxRawBytes - 1));

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    esc_d     = esc_q;
    nlskip_d  = nlskip_q;
    oct_act_d = oct_act_q;
    oct_val_d = oct_val_q;
    oct_dig_d = oct_dig_q;
    nib_d     = nib_q;
    hi_d      = hi_q;
    raw_d     = raw_q;
    nb        = 2'd0;
    b0        = '0;
    b1        = '0;
    done      = 1'b0;
    closed    = 1'b0;
    plain     = 1'b0;
    status    = StComplete;

    unique case (mode_q)
      ModeLit: begin
        if (tok_i.eoi) begin
          if (oct_act_q) begin
            b0 = oct_val_q;
            nb = 2'd1;
          end
          done   = 1'b1;
          status = StEndOfInput;
        end else begin
          plain = 1'b1;
          if (oct_act_q) begin
            if (tok_i.is_oct && (oct_dig_q != 2'd3) && (oct_val_q[7:5] == 3'd0)) begin
              plain     = 1'b0;
              oct_val_d = {oct_val_q[4:0], tok_i.ch[2:0]};
              oct_dig_d = oct_dig_q + 2'd1;
              if (oct_dig_q == 2'd2) begin
                b0        = oct_val_d;
                nb        = 2'd1;
                oct_act_d = 1'b0;
              end
            end else begin
              b0        = oct_val_q;
              nb        = 2'd1;
              oct_act_d = 1'b0;
            end
          end
          if (plain && nlskip_q) begin
            nlskip_d = 1'b0;
            if (tok_i.ch == ChLf) begin
              plain = 1'b0;
            end
          end
          if (plain) begin
            priority if (esc_q) begin
              esc_d = 1'b0;
              unique case (tok_i.esc_kind)
                EscCr: nlskip_d = 1'b1;
                EscLf: nlskip_d = nlskip_d;
                EscOct: begin
                  oct_act_d = 1'b1;
                  oct_val_d = {5'd0, tok_i.ch[2:0]};
                  oct_dig_d = 2'd1;
                end
                default: begin
                  if (nb == 2'd0) b0 = tok_i.esc_byte;
                  else b1 = tok_i.esc_byte;
                  nb = nb + 2'd1;
                end
              endcase
            end else if (tok_i.ch == ChBackslash) begin
              esc_d = 1'b1;
            end else if (tok_i.ch == ChRParen && depth_q <= DepthW'(1)) begin
              depth_d = '0;
              closed  = 1'b1;
            end else begin
              if (tok_i.ch == ChLParen && depth_q != DepthMax) begin
                depth_d = depth_q + 1'b1;
              end else if (tok_i.ch == ChRParen) begin
                depth_d = depth_q - 1'b1;
              end
              if (nb == 2'd0) b0 = tok_i.ch;
              else b1 = tok_i.ch;
              nb = nb + 2'd1;
            end
          end
          if (closed) begin
            done   = 1'b1;
            status = StComplete;
          end else begin
            raw_d = raw_q + 1'b1;
            if (limit) begin
              if (oct_act_d) begin
                if (nb == 2'd0) b0 = oct_val_d;
                else b1 = oct_val_d;
                nb = nb + 2'd1;
              end
              done   = 1'b1;
              status = StLengthLimit;
            end
          end
        end
      end
      ModeHex: begin
        if (tok_i.eoi || tok_i.ch == ChGreater) begin
          if (nib_q) begin
            b0 = {hi_q, 4'd0};
            nb = 2'd1;
          end
          done   = 1'b1;
          status = tok_i.eoi ? StEndOfInput : StComplete;
        end else begin
          if (tok_i.is_hex) begin
            if (nib_q) begin
              b0    = {hi_q, tok_i.hex_val};
              nb    = 2'd1;
              nib_d = 1'b0;
            end else begin
              hi_d  = tok_i.hex_val;
              nib_d = 1'b1;
            end
          end
          raw_d = raw_q + 1'b1;
          if (limit) begin
            if (nib_d) begin
              if (nb == 2'd0) b0 = {hi_d, 4'd0};
              else b1 = {hi_d, 4'd0};
              nb = nb + 2'd1;
            end
            done   = 1'b1;
            status = StLengthLimit;
          end
        end
      end
      default: begin
        if (tok_i.eoi || !tok_i.is_space) begin
          depth_d   = '0;
          esc_d     = 1'b0;
          nlskip_d  = 1'b0;
          oct_act_d = 1'b0;
          oct_val_d = '0;
          oct_dig_d = '0;
          nib_d     = 1'b0;
          hi_d      = '0;
          raw_d     = '0;
          priority if (!tok_i.eoi && tok_i.ch == ChLParen) begin
            mode_d  = ModeLit;
            depth_d = DepthW'(1);
          end else if (!tok_i.eoi && tok_i.ch == ChLess) begin
            mode_d  = ModeHex;
          end else begin
            mode_d  = ModeIdle;
            done    = 1'b1;
            status  = StNoString;
          end
        end
      end
    endcase

    if (done) begin
      mode_d    = ModeIdle;
      depth_d   = '0;
      esc_d     = 1'b0;
      nlskip_d  = 1'b0;
      oct_act_d = 1'b0;
      oct_val_d = '0;
      oct_dig_d = '0;
      nib_d     = 1'b0;
      hi_d      = '0;
      raw_d     = '0;
    end
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    if (done && nb == 2'd0) begin
      n_res          = 2'd1;
      r0.string_done = 1'b1;
      r0.end_status  = status;
    end else begin
      n_res          = nb;
      r0.out_byte    = b0;
      r0.byte_valid  = 1'b1;
      r0.string_done = done && (nb == 2'd1);
      r0.end_status  = (done && nb == 2'd1) ? status : StComplete;
    end
    r1.out_byte    = b1;
    r1.byte_valid  = 1'b1;
    r1.string_done = done;
    r1.end_status  = done ? status : StComplete;
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign tok_pop_o   = tok_valid_i && ((n_res == 2'd0) || (!spill_valid_q && out_free));
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeIdle;
      depth_q       <= '0;
      esc_q         <= 1'b0;
      nlskip_q      <= 1'b0;
      oct_act_q     <= 1'b0;
      oct_val_q     <= '0;
      oct_dig_q     <= '0;
      nib_q         <= 1'b0;
      hi_q          <= '0;
      raw_q         <= '0;
      out_valid_q   <= 1'b0;
      spill_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        mode_q    <= mode_d;
        depth_q   <= depth_d;
        esc_q     <= esc_d;
        nlskip_q  <= nlskip_d;
        oct_act_q <= oct_act_d;
        oct_val_q <= oct_val_d;
        oct_dig_q <= oct_dig_d;
        nib_q     <= nib_d;
        hi_q      <= hi_d;
        raw_q     <= raw_d;
      end
      if (out_free) begin
        if (spill_valid_q) begin
          out_valid_q   <= 1'b1;
          spill_valid_q <= 1'b0;
        end else if (tok_pop_o && n_res != 2'd0) begin
          out_valid_q   <= 1'b1;
          spill_valid_q <= (n_res == 2'd2);
        end else begin
          out_valid_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (spill_valid_q) begin
        out_q <= spill_q;
      end else if (tok_pop_o && n_res != 2'd0) begin
        out_q   <= r0;
        spill_q <= r1;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/pdf_string_checker.sv
`timescale 1ns / 1ps
module pdf_string_checker #(
  parameter int unsigned MaxRawBytes = psd_pkg::MaxRawBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  psd_pkg::in_t  in_i,
  input  logic          in_stall_i,
  input  logic          out_valid_i,
  input  psd_pkg::out_t out_i,
  input  logic          out_stall_i,
  output int            err_count_o,
  output int            pending_o
);
  import psd_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeLit  = 2'd1,
    ModeHex  = 2'd2
  } mode_e;

  mode_e             mode_q = ModeIdle;
  logic [DepthW-1:0] depth_q = '0;
  logic              esc_q = 1'b0;
  logic              nl_skip_q = 1'b0;
  logic              oct_act_q = 1'b0;
  logic [7:0]        oct_val_q = '0;
  logic [1:0]        oct_cnt_q = '0;
  logic              nib_q = 1'b0;
  logic [3:0]        hi_nib_q = '0;
  logic [8:0]        raw_cnt_q = '0;

  logic [7:0] step_bytes [2];
  int         step_n;
  out_t       decoded_q [$];
  int         errors = 0;
  int         pending = 0;

  assign err_count_o = errors;
  assign pending_o   = pending;

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChNul || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  task automatic clear_string();
    depth_q   = '0;
    esc_q     = 1'b0;
    nl_skip_q = 1'b0;
    oct_act_q = 1'b0;
    oct_val_q = '0;
    oct_cnt_q = '0;
    nib_q     = 1'b0;
    hi_nib_q  = '0;
    raw_cnt_q = '0;
  endtask

  task automatic add_byte(logic [7:0] b);
    step_bytes[step_n] = b;
    step_n++;
  endtask

  task automatic literal_char(input logic [7:0] c, output logic closed);
    logic skip;
    closed    = 1'b0;
    skip      = nl_skip_q && c == ChLf;
    nl_skip_q = 1'b0;
    if (!skip) begin
      if (esc_q) begin
        esc_q = 1'b0;
        case (c)
          ChLowN: add_byte(ChLf);
          ChLowR: add_byte(ChCr);
          ChLowT: add_byte(ChTab);
          ChLowB: add_byte(ChBs);
          ChLowF: add_byte(ChFf);
          ChCr:   nl_skip_q = 1'b1;
          ChLf:   ;
          default: begin
            if (is_octal(c)) begin
              oct_act_q = 1'b1;
              oct_val_q = c - ChZero;
              oct_cnt_q = 2'd1;
            end else begin
              add_byte(c);
            end
          end
        endcase
      end else if (c == ChBackslash) begin
        esc_q = 1'b1;
      end else if (c == ChRParen && depth_q <= 1) begin
        depth_q = '0;
        closed  = 1'b1;
      end else begin
        if (c == ChLParen) begin
          if (depth_q != DepthMax) depth_q++;
        end else if (c == ChRParen) begin
          depth_q--;
        end
        add_byte(c);
      end
    end
  endtask

  task automatic decode_request(input in_t req);
    logic [7:0]  c;
    logic        eoi;
    logic        done;
    logic        closed;
    status_e     st;
    logic [10:0] nv;
    int          hv;
    int          k;
    out_t        r;
    c      = req.data_byte;
    eoi    = req.end_of_input;
    done   = 1'b0;
    closed = 1'b0;
    st     = StComplete;
    step_n = 0;
    case (mode_q)
      ModeLit: begin
        if (eoi) begin
          if (oct_act_q) add_byte(oct_val_q);
          done = 1'b1;
          st   = StEndOfInput;
        end else begin
          if (oct_act_q) begin
            nv = {3'b000, oct_val_q} * 11'd8 + {3'b000, c - ChZero};
            if (is_octal(c) && oct_cnt_q < 2'd3 && nv < 11'd256) begin
              oct_val_q = nv[7:0];
              oct_cnt_q++;
              if (oct_cnt_q == 2'd3) begin
                add_byte(oct_val_q);
                oct_act_q = 1'b0;
              end
            end else begin
              add_byte(oct_val_q);
              oct_act_q = 1'b0;
              literal_char(c, closed);
            end
          end else begin
            literal_char(c, closed);
          end
          if (closed) begin
            done = 1'b1;
            st   = StComplete;
          end else begin
            raw_cnt_q++;
            if (raw_cnt_q >= MaxRawBytes) begin
              if (oct_act_q && step_n < 2) add_byte(oct_val_q);
              done = 1'b1;
              st   = StLengthLimit;
            end
          end
        end
      end
      ModeHex: begin
        if (eoi || c == ChGreater) begin
          if (nib_q) add_byte({hi_nib_q, 4'h0});
          done = 1'b1;
          st   = eoi ? StEndOfInput : StComplete;
        end else begin
          hv = hex_digit(c);
          if (hv >= 0) begin
            if (nib_q) begin
              add_byte({hi_nib_q, hv[3:0]});
              nib_q = 1'b0;
            end else begin
              hi_nib_q = hv[3:0];
              nib_q    = 1'b1;
            end
          end
          raw_cnt_q++;
          if (raw_cnt_q >= MaxRawBytes) begin
            if (nib_q && step_n < 2) add_byte({hi_nib_q, 4'h0});
            done = 1'b1;
            st   = StLengthLimit;
          end
        end
      end
      default: begin
        if (eoi || !is_blank(c)) begin
          clear_string();
          if (!eoi && c == ChLParen) begin
            mode_q  = ModeLit;
            depth_q = DepthW'(1);
          end else if (!eoi && c == ChLess) begin
            mode_q = ModeHex;
          end else begin
            mode_q = ModeIdle;
            done   = 1'b1;
            st     = StNoString;
          end
        end
      end
    endcase
    if (done) begin
      mode_q = ModeIdle;
      clear_string();
    end
    for (k = 0; k < step_n; k++) begin
      r.out_byte    = step_bytes[k];
      r.byte_valid  = 1'b1;
      r.string_done = done && k == step_n - 1;
      r.end_status  = r.string_done ? st : StComplete;
      decoded_q.push_back(r);
    end
    if (done && step_n == 0) begin
      r             = '0;
      r.string_done = 1'b1;
      r.end_status  = st;
      decoded_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      mode_q = ModeIdle;
      clear_string();
      decoded_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) decode_request(in_i);
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", int'(out_i), 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_i.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_i.out_byte), int'(want.out_byte));
          if (out_i.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(out_i.byte_valid), int'(want.byte_valid));
          if (out_i.string_done !== want.string_done)
            report_mismatch("string_done", int'(out_i.string_done),
                            int'(want.string_done));
          if (out_i.end_status !== want.end_status)
            report_mismatch("end_status", int'(out_i.end_status), int'(want.end_status));
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import psd_pkg::*;

  localparam int TotalItems = 1150;
  localparam int HoldCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_req = '0;
  logic in_stall;
  logic out_valid;
  out_t out_res;
  logic out_stall = 1'b0;

  int errors;
  int pending;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;

  logic [7:0] esc_chars [8] = '{ChLowN, ChLowR, ChLowT, ChLowB, ChLowF,
                                ChLParen, ChRParen, ChBackslash};

  always #5 clk = ~clk;

  pdf_string_token_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_i        (in_req),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_o       (out_res),
    .out_stall_i (out_stall)
  );

  pdf_string_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_i        (in_req),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_i       (out_res),
    .out_stall_i (out_stall),
    .err_count_o (errors),
    .pending_o   (pending)
  );

  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_served) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{data_byte: b, end_of_input: eoi};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_eoi();
    send(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(s[i], 1'b0);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChLParen || b == ChRParen || b == ChBackslash);
    return b;
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return 8'(ChZero + k);
    if (k < 16) return 8'(ChLowA + k - 10);
    return 8'(ChUpA + k - 16);
  endfunction

  task automatic rand_literal();
    int depth;
    int n;
    int op;
    send(ChLParen, 1'b0);
    depth = 1;
    n = $urandom_range(12);
    repeat (n) begin
      op = $urandom_range(9);
      case (op)
        0, 1, 2: send(plain_byte(), 1'b0);
        3: begin
          send(ChLParen, 1'b0);
          depth++;
        end
        4: begin
          if (depth > 1) begin
            send(ChRParen, 1'b0);
            depth--;
          end
        end
        5: begin
          send(ChBackslash, 1'b0);
          send(esc_chars[3'($urandom_range(7))], 1'b0);
        end
        6: begin
          send(ChBackslash, 1'b0);
          repeat ($urandom_range(4, 1)) send(8'(ChZero + $urandom_range(7)), 1'b0);
        end
        7: begin
          send(ChBackslash, 1'b0);
          send(8'($urandom_range(255)), 1'b0);
        end
        8: begin
          send(ChBackslash, 1'b0);
          send(ChCr, 1'b0);
          if ($urandom_range(1)) send(ChLf, 1'b0);
        end
        default: begin
          send(ChBackslash, 1'b0);
          send(ChLf, 1'b0);
        end
      endcase
    end
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1)) send(ChBackslash, 1'b0);
      send_eoi();
    end else begin
      repeat (depth) send(ChRParen, 1'b0);
    end
  endtask

  task automatic rand_hex();
    logic [7:0] b;
    send(ChLess, 1'b0);
    repeat ($urandom_range(12)) begin
      if ($urandom_range(3) != 0) begin
        send(hex_char(), 1'b0);
      end else begin
        do b = 8'($urandom_range(255)); while (b == ChGreater);
        send(b, 1'b0);
      end
    end
    if ($urandom_range(9) == 0) send_eoi();
    else send(ChGreater, 1'b0);
  endtask

  task automatic rand_noise();
    logic [7:0] b;
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) begin
      send_eoi();
    end else if (pick == 1) begin
      pick = $urandom_range(6);
      b = pick == 0 ? ChNul : pick == 1 ? ChSpace : 8'(ChTab + pick - 2);
      send(b, 1'b0);
    end else begin
      do b = 8'($urandom_range(255)); while (b == ChLParen || b == ChLess);
      send(b, 1'b0);
    end
  endtask

  initial begin
    int base;
    int seq;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(ChNul, 1'b0);
    send(8'hff, 1'b0);
    send_eoi();
    send_text("(a\\)\\t\\8\\");
    send(ChCr, 1'b0);
    send(ChLf, 1'b0);
    send_text("\\477)");
    send_text("<4F a>");
    send_text("(\\");
    send_eoi();

    hold_reqs++;
    send(ChLParen, 1'b0);
    repeat (MaxRawBytesDef - 2) send(plain_byte(), 1'b0);
    send(ChBackslash, 1'b0);
    send(ChZero + 8'd1, 1'b0);

    send(ChLess, 1'b0);
    repeat (MaxRawBytesDef - 2) send(hex_char(), 1'b0);
    send(ChSpace, 1'b0);
    send(hex_char(), 1'b0);

    base = sent;
    while (sent < TotalItems) begin
      case (((sent - base) * 4) / (TotalItems - base))
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      seq = $urandom_range(9);
      if (seq < 4) rand_literal();
      else if (seq < 7) rand_hex();
      else repeat ($urandom_range(3, 1)) rand_noise();
    end
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
